[src/spcq_pkg.sv]
// Shared types and constants for the strict-priority class queue.
// Depends on nothing; imported by the top module and the checker.
package spcq_pkg;

  // Sizing
  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned CLASS_DEPTH = 64;
  localparam int unsigned PKT_MAX     = 16383;

  localparam int unsigned CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SLOT_W  = $clog2(CLASS_DEPTH);
  localparam int unsigned CNT_W   = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned CB_W    = $clog2(CLASS_DEPTH * PKT_MAX + 1);
  localparam int unsigned AH_W    = $clog2(NUM_CLASSES * CLASS_DEPTH * PKT_MAX + 1);
  localparam int unsigned RAM_DEP = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(RAM_DEP);

  // Word modes
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_SERVE  = 1'b1;

  // Packet kinds
  localparam logic [3:0] KIND_TCP     = 4'd0;
  localparam logic [3:0] KIND_TCPACK  = 4'd1;
  localparam logic [3:0] KIND_NDP     = 4'd2;
  localparam logic [3:0] KIND_NDPACK  = 4'd3;
  localparam logic [3:0] KIND_NDPNACK = 4'd4;
  localparam logic [3:0] KIND_NDPPULL = 4'd5;
  localparam logic [3:0] KIND_LITE_C0 = 4'd6;
  localparam logic [3:0] KIND_LITE_C1 = 4'd7;
  localparam logic [3:0] KIND_LITE_C2 = 4'd8;
  localparam logic [3:0] KIND_IP      = 4'd9;
  localparam logic [3:0] KIND_NDPLITE = 4'd10;
  localparam logic [3:0] KIND_RLB     = 4'd11;

  // Class codes
  localparam logic [1:0] CLS_RLB = 2'd0;
  localparam logic [1:0] CLS_LO  = 2'd1;
  localparam logic [1:0] CLS_MID = 2'd2;
  localparam logic [1:0] CLS_HI  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KIND = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_THRESH = 1'b0;
  localparam logic CFG_PS     = 1'b1;
  localparam logic [15:0] PS_RESET = 16'd80;

  typedef struct packed {
    logic        mode;
    logic [3:0]  packet_kind;
    logic        hdr_only;
    logic [47:0] flow_size;
    logic [13:0] packet_bytes;
    logic [15:0] packet_id;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  error_code;
    logic [1:0]  assigned_class;
    logic [51:0] wait_ps;
    logic        depart_valid;
    logic [15:0] depart_id;
    logic [13:0] depart_bytes;
    logic [1:0]  depart_class;
    logic [21:0] total_bytes;
  } out_word_t;

  // One stored descriptor
  typedef struct packed {
    logic [15:0] id;
    logic [13:0] bytes;
  } slot_t;

endpackage

[src/spcq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/strict_priority_class_queue.sv]
// Strict-priority four-class descriptor queue: classify, enqueue, serve.
// Depends on spcq_pkg and spcq_ram.
//
//   channel   handshake                 word             direction
//   in        in_valid_i / in_stall_o   in_word_i        arrival or service request
//   out       out_valid_o / out_stall_i out_word_o       one result per input word
//   cfg       cfg_we_i                  cfg_idx_i/data   register write
//
// One input word per cycle while in_stall_o is low; its result is registered
// in stage 1 and then in the output register before it reaches out_word_o.
// The decision and queue state updates happen at the accept edge, save a pop's
// byte removal, applied once the RAM data is back; the descriptor RAM read and the wait multiply fill the second stage.
// Output stalls back up into in_stall_o only once both stages are full.
// Reset empties all classes and loads threshold 0, ps_per_byte 80.
module strict_priority_class_queue
  import spcq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  // second-stage record
  typedef struct packed {
    logic             accepted;
    logic [1:0]       error_code;
    logic [1:0]       assigned_class;
    logic [AH_W-1:0]  ahead;
    logic             depart_valid;
    logic [CLS_W-1:0] depart_class;
  } stage_t;

  // configuration
  logic [47:0] thresh_q;
  logic [15:0] ps_q;

  // queue state
  logic [SLOT_W-1:0] head_q [NUM_CLASSES];
  logic [SLOT_W-1:0] head_d [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_d  [NUM_CLASSES];
  logic [CB_W-1:0]   cb_q   [NUM_CLASSES];
  logic [CB_W-1:0]   cb_d   [NUM_CLASSES];
  logic [CB_W-1:0]   eff    [NUM_CLASSES];
  logic [AH_W-1:0]   suf    [NUM_CLASSES];
  logic [AH_W-1:0]   total_eff;

  // pending byte removal of the last pop, resolved once the RAM data is back
  logic             pend_q;
  logic [CLS_W-1:0] pend_cls_q;

  // pipeline registers
  logic             s1_valid_q, s1_fresh_q;
  stage_t           s1_q, s1_d;
  logic [21:0]      s1_total_q;
  logic             out_valid_q;
  out_word_t        out_word_q, out_word_d;

  // decode
  logic             in_acc, s1_adv;
  logic             kind_ok;
  logic [1:0]       raw_cls;
  logic [CLS_W-1:0] k;
  logic             full, do_push, do_pop, found;
  logic [CLS_W-1:0] sel;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W:0]   tail_sum;

  // RAM
  logic [ADDR_W-1:0] waddr, raddr;
  slot_t             wdata, rdata;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
      ps_q     <= PS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_THRESH) begin
        thresh_q <= cfg_data_i;
      end else begin
        ps_q <= cfg_data_i[15:0];
      end
    end
  end

  // classification
  always_comb begin
    kind_ok = 1'b1;
    raw_cls = CLS_RLB;
    unique case (in_word_i.packet_kind)
      KIND_TCP, KIND_TCPACK: raw_cls = (in_word_i.flow_size >= thresh_q) ? CLS_LO : CLS_HI;
      KIND_NDP:              raw_cls = in_word_i.hdr_only ? CLS_HI : CLS_MID;
      KIND_NDPACK, KIND_NDPNACK, KIND_NDPPULL,
      KIND_LITE_C0, KIND_LITE_C1, KIND_LITE_C2: raw_cls = CLS_HI;
      KIND_IP, KIND_NDPLITE: raw_cls = CLS_LO;
      KIND_RLB:              raw_cls = CLS_RLB;
      default:               kind_ok = 1'b0;
    endcase
    // fewer classes than codes: clamp to the top class
    if (int'(raw_cls) >= NUM_CLASSES) begin
      k = CLS_W'(NUM_CLASSES - 1);
    end else begin
      k = CLS_W'(raw_cls);
    end
  end

  // byte totals with the pending pop applied, and suffix sums for the wait
  always_comb begin
    logic [AH_W-1:0] acc;
    logic [CB_W-1:0] pb;
    acc = '0;
    pb  = CB_W'(rdata.bytes);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (pend_q && pend_cls_q == CLS_W'(c)) begin
        eff[c] = (cb_q[c] >= pb) ? cb_q[c] - pb : '0;
      end else begin
        eff[c] = cb_q[c];
      end
    end
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      acc    = acc + AH_W'(eff[c]);
      suf[c] = acc;
    end
    total_eff = suf[0];
  end

  // highest nonempty class
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cnt_q[c] != '0) begin
        found = 1'b1;
        sel   = CLS_W'(c);
      end
    end
  end

  // push / pop decisions and tail slot
  always_comb begin
    full     = cnt_q[k] >= CNT_W'(CLASS_DEPTH);
    do_push  = in_acc && (in_word_i.mode == MODE_ARRIVE) && kind_ok && !full;
    do_pop   = in_acc && (in_word_i.mode == MODE_SERVE) && found;
    tail_sum = (CNT_W+1)'(head_q[k]) + (CNT_W+1)'(cnt_q[k]);
    if (tail_sum >= (CNT_W+1)'(CLASS_DEPTH)) begin
      tail = SLOT_W'(tail_sum - (CNT_W+1)'(CLASS_DEPTH));
    end else begin
      tail = SLOT_W'(tail_sum);
    end
  end

  // next queue state
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_d[c] = head_q[c];
      cnt_d[c]  = cnt_q[c];
      cb_d[c]   = eff[c];
    end
    if (do_push) begin
      cnt_d[k] = cnt_q[k] + CNT_W'(1);
      cb_d[k]  = eff[k] + CB_W'(in_word_i.packet_bytes);
    end
    if (do_pop) begin
      cnt_d[sel] = cnt_q[sel] - CNT_W'(1);
      if (head_q[sel] == SLOT_W'(CLASS_DEPTH - 1)) begin
        head_d[sel] = '0;
      end else begin
        head_d[sel] = head_q[sel] + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
        cb_q[c]   <= '0;
      end
      pend_q     <= 1'b0;
      pend_cls_q <= '0;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= head_d[c];
        cnt_q[c]  <= cnt_d[c];
        cb_q[c]   <= cb_d[c];
      end
      pend_q     <= do_pop;
      pend_cls_q <= sel;
    end
  end

  // descriptor store
  assign wdata.id    = in_word_i.packet_id;
  assign wdata.bytes = in_word_i.packet_bytes;
  assign waddr = ADDR_W'(k) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(tail);
  assign raddr = ADDR_W'(sel) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(head_q[sel]);

  spcq_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (RAM_DEP)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (do_pop),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // stage 1 record
  always_comb begin
    s1_d = '0;
    if (in_word_i.mode == MODE_ARRIVE) begin
      s1_d.accepted       = do_push;
      s1_d.assigned_class = kind_ok ? 2'(k) : CLS_RLB;
      s1_d.ahead          = do_push ? suf[k] : '0;
      if (!kind_ok) begin
        s1_d.error_code = ERR_KIND;
      end else if (full) begin
        s1_d.error_code = ERR_FULL;
      end else begin
        s1_d.error_code = ERR_NONE;
      end
    end else begin
      s1_d.depart_valid = found;
      s1_d.depart_class = found ? sel : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fresh_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !s1_adv);
      s1_fresh_q <= in_acc;
    end
  end

  // the total after a word is seen in the cycle right after its accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_fresh_q) begin
      s1_total_q <= 22'(total_eff);
    end
  end

  // result word
  always_comb begin
    out_word_d                = '0;
    out_word_d.accepted       = s1_q.accepted;
    out_word_d.error_code     = s1_q.error_code;
    out_word_d.assigned_class = s1_q.assigned_class;
    out_word_d.wait_ps        = 52'(s1_q.ahead * (AH_W+16)'(ps_q));
    out_word_d.depart_valid   = s1_q.depart_valid;
    out_word_d.depart_class   = 2'(s1_q.depart_class);
    out_word_d.depart_id      = s1_q.depart_valid ? rdata.id : '0;
    out_word_d.depart_bytes   = s1_q.depart_valid ? rdata.bytes : '0;
    out_word_d.total_bytes    = s1_fresh_q ? 22'(total_eff) : s1_total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[src/spcq_checker.sv]
// Port-level checks for the strict-priority class queue, bound to the top.
// Depends on spcq_pkg.
module spcq_checker
  import spcq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_word_t   out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // an enqueued arrival carries no error and no departure
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.accepted |->
      out_word_o.error_code == ERR_NONE && !out_word_o.depart_valid)
    else $error("accepted arrival with error or departure");

  // a dropped or service word reports no wait
  a_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.accepted |-> out_word_o.wait_ps == '0)
    else $error("wait reported without enqueue");

  // an unknown kind reports the rlb class and no departure
  a_kind_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error_code == ERR_KIND |->
      out_word_o.assigned_class == CLS_RLB && !out_word_o.depart_valid)
    else $error("bad fields on unknown kind");

endmodule

bind strict_priority_class_queue spcq_checker u_spcq_checker (.*);
